// ===== src/rbta_pkg.sv =====
package rbta_pkg;

  // Default grid side; storage is GRID_MAX rows of GRID_MAX cells
  localparam int unsigned RBTA_GRID_MAX = 64;

  // Request modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_RUN   = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Cell codes
  localparam logic [1:0] CELL_EMPTY = 2'd0;
  localparam logic [1:0] CELL_RED   = 2'd1;
  localparam logic [1:0] CELL_BLUE  = 2'd2;
  localparam logic [1:0] CELL_BAD   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_GRID_SIZE = 2'd0;
  localparam logic [1:0] CFG_TILE_SIZE = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD = 2'd2;
  localparam logic [1:0] CFG_MAX_ITER  = 2'd3;

  localparam int unsigned RBTA_PCT   = 100;
  localparam int unsigned RBTA_CFG_W = 7;
  localparam int unsigned RBTA_TT_W  = 2 * RBTA_CFG_W;
  localparam int unsigned RBTA_BND_W = 3 * RBTA_CFG_W;
  localparam int unsigned RBTA_MIN_SIDE = 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_DT,
    ST_INIT_TT,
    ST_INIT_BND,
    ST_CHK_RD,
    ST_CHK_DT,
    ST_CHK_WAIT,
    ST_RED_RD,
    ST_RED_DT,
    ST_BLU_RD,
    ST_BLU_DT,
    ST_BLU_LAST,
    ST_RESP
  } rbta_state_e;

  typedef struct packed {
    logic start;       // clear the hit flag
    logic row_vld;     // a grid row is on the data bus
    logic band_first;  // first row of a tile band
    logic band_last;   // last row of a tile band: sweep columns after it
  } rbta_tile_ctl_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } rbta_tile_sts_t;

endpackage

// ===== src/rbta_if.sv =====
interface rbta_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [5:0] row;
  logic [5:0] col;
  logic [1:0] colour;

  modport source (output valid, output mode, output row, output col, output colour,
                  input ready);
  modport sink (input valid, input mode, input row, input col, input colour,
                output ready);
endinterface

interface rbta_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cell_value;
  logic        done_flag;
  logic [15:0] steps_done;

  modport source (output valid, output cell_value, output done_flag, output steps_done,
                  input ready);
  modport sink (input valid, input cell_value, input done_flag, input steps_done,
                output ready);
endinterface

// ===== src/red_blue_torus_automaton.sv =====
// Channel   Dir   Payload                              Accepted when
// req_i     in    mode, row, col, colour               valid & ready
// rsp_o     out   cell_value, done_flag, steps_done    valid & ready
// cfg       in    cfg_we_i, cfg_idx_i, cfg_data_i      cfg_we_i high
//
// The grid lives in one row-wide RAM (one row of cells per word), so every
// cell write is a read, a modify and a write-back of a whole row.
// Cell write/read: read row, then modify or select, then respond.
// Run: setup forms tile area and bound; each finish check reads every row and
// sweeps each full tile band; each step is a red pass, then a blue pass.
// Reset clears control state only; the grid holds garbage until written.
// A finished result waits in the output register; a new request is taken once
// the sequencer is idle, and only the final hand-off waits on rsp_o.ready.
module red_blue_torus_automaton
  import rbta_pkg::*;
#(
  parameter int unsigned GridMax = RBTA_GRID_MAX
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rbta_req_if.sink    req_i,
  rbta_rsp_if.source  rsp_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned SideW = $clog2(GridMax + 1);
  localparam int unsigned IdxW  = $clog2(GridMax);
  localparam int unsigned CmpW  = (SideW > RBTA_CFG_W ? SideW : RBTA_CFG_W) + 1;

  typedef logic [GridMax-1:0][1:0] row_t;

  // Configuration registers
  logic [RBTA_CFG_W-1:0] grid_q;
  logic [RBTA_CFG_W-1:0] tile_q;
  logic [RBTA_CFG_W-1:0] thr_q;
  logic [15:0]           maxit_q;

  // Sequencer state
  rbta_state_e st_q, st_d;
  logic [1:0]  mode_q, mode_d;
  logic [5:0]  row_q, row_d;
  logic [5:0]  col_q, col_d;
  logic [1:0]  colour_q, colour_d;
  logic [SideW-1:0] rowc_q, rowc_d;
  logic [SideW-1:0] rb_q, rb_d;
  logic [SideW-1:0] bc_q, bc_d;
  logic [15:0] k_q, k_d;
  logic        moved_q, moved_d;
  logic [RBTA_TT_W-1:0]  tt_q, tt_d;
  logic [RBTA_BND_W-1:0] bound_q, bound_d;
  row_t        prev_q, prev_d;
  row_t        cur_q, cur_d;
  row_t        save_q, save_d;
  logic [1:0]  res_val_q, res_val_d;
  logic        res_done_q, res_done_d;
  logic [15:0] res_steps_q, res_steps_d;

  // Output register
  logic        out_vld_q;
  logic [1:0]  out_val_q;
  logic        out_done_q;
  logic [15:0] out_steps_q;
  logic        out_load;

  // Memory port
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  row_t            ram_wdata;
  logic [IdxW-1:0] ram_raddr;
  row_t            ram_rdata;

  // Datapath
  logic [SideW-1:0] side;
  logic             tiles_ok;
  logic             in_range;
  logic             band_last;
  logic [IdxW-1:0]  col_idx;
  logic [1:0]       wr_colour;
  row_t             cell_row;
  row_t             upd_cur;
  row_t             upd_next;
  row_t             upd_row;
  logic             upd_changed;
  logic             upd_red;
  rbta_tile_ctl_t   tile_ctl;
  rbta_tile_sts_t   tile_sts;

  // Clamp the active side into [2, GridMax]
  always_comb begin
    if (grid_q < RBTA_CFG_W'(RBTA_MIN_SIDE)) begin
      side = SideW'(RBTA_MIN_SIDE);
    end else if (CmpW'(grid_q) > CmpW'(GridMax)) begin
      side = SideW'(GridMax);
    end else begin
      side = SideW'(grid_q);
    end
  end

  assign tiles_ok  = (tile_q != '0) && (CmpW'(tile_q) <= CmpW'(side));
  assign in_range  = (CmpW'(row_q) < CmpW'(side)) && (CmpW'(col_q) < CmpW'(side));
  assign band_last = CmpW'(rb_q) == CmpW'(tile_q) - CmpW'(1);
  assign col_idx   = IdxW'(col_q);
  assign wr_colour = (colour_q == CELL_BAD) ? CELL_EMPTY : colour_q;

  always_comb begin
    cell_row          = ram_rdata;
    cell_row[col_idx] = wr_colour;
  end

  rbta_ram #(
    .Width (2 * GridMax),
    .Depth (GridMax)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign upd_red  = (st_q == ST_RED_DT);
  assign upd_cur  = upd_red ? ram_rdata : cur_q;
  assign upd_next = (st_q == ST_BLU_LAST) ? save_q : ram_rdata;

  rbta_row_upd #(
    .GridMax (GridMax)
  ) u_row_upd (
    .is_red_i  (upd_red),
    .side_i    (side),
    .prev_i    (prev_q),
    .cur_i     (upd_cur),
    .next_i    (upd_next),
    .row_o     (upd_row),
    .changed_o (upd_changed)
  );

  assign tile_ctl.start      = (st_q == ST_INIT_BND) || (st_q == ST_BLU_LAST);
  assign tile_ctl.row_vld    = (st_q == ST_CHK_DT) && tiles_ok;
  assign tile_ctl.band_first = (rb_q == '0);
  assign tile_ctl.band_last  = band_last;

  rbta_tile_chk #(
    .GridMax (GridMax)
  ) u_tile_chk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (tile_ctl),
    .row_i   (ram_rdata),
    .side_i  (side),
    .tile_i  (tile_q),
    .bound_i (bound_q),
    .sts_o   (tile_sts)
  );

  assign req_i.ready = (st_q == ST_IDLE);
  assign out_load    = (st_q == ST_RESP) && (!out_vld_q || rsp_o.ready);

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.cell_value = out_val_q;
  assign rsp_o.done_flag  = out_done_q;
  assign rsp_o.steps_done = out_steps_q;

  // Next state and datapath control
  always_comb begin
    st_d        = st_q;
    mode_d      = mode_q;
    row_d       = row_q;
    col_d       = col_q;
    colour_d    = colour_q;
    rowc_d      = rowc_q;
    rb_d        = rb_q;
    bc_d        = bc_q;
    k_d         = k_q;
    moved_d     = moved_q;
    tt_d        = tt_q;
    bound_d     = bound_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    save_d      = save_q;
    res_val_d   = res_val_q;
    res_done_d  = res_done_q;
    res_steps_d = res_steps_q;
    ram_we      = 1'b0;
    ram_waddr   = IdxW'(rowc_q);
    ram_wdata   = upd_row;
    ram_raddr   = IdxW'(rowc_q);

    unique case (st_q)
      ST_IDLE: begin
        res_val_d   = CELL_EMPTY;
        res_done_d  = 1'b0;
        res_steps_d = '0;
        if (req_i.valid) begin
          mode_d   = req_i.mode;
          row_d    = req_i.row;
          col_d    = req_i.col;
          colour_d = req_i.colour;
          priority case (req_i.mode)
            MODE_RUN:               st_d = ST_INIT_TT;
            MODE_WRITE, MODE_READ:  st_d = ST_CELL_RD;
            default:                st_d = ST_RESP;
          endcase
        end
      end
      ST_CELL_RD: begin
        ram_raddr = IdxW'(row_q);
        st_d      = in_range ? ST_CELL_DT : ST_RESP;
      end
      ST_CELL_DT: begin
        ram_waddr = IdxW'(row_q);
        ram_wdata = cell_row;
        if (mode_q == MODE_WRITE) begin
          ram_we = 1'b1;
        end else begin
          res_val_d = ram_rdata[col_idx];
        end
        st_d = ST_RESP;
      end
      ST_INIT_TT: begin
        tt_d = RBTA_TT_W'(tile_q) * RBTA_TT_W'(tile_q);
        st_d = ST_INIT_BND;
      end
      ST_INIT_BND: begin
        bound_d = RBTA_BND_W'(thr_q) * RBTA_BND_W'(tt_q);
        k_d     = '0;
        rowc_d  = '0;
        rb_d    = '0;
        st_d    = ST_CHK_RD;
      end
      ST_CHK_RD: begin
        st_d = ST_CHK_DT;
      end
      ST_CHK_DT: begin
        rowc_d = rowc_q + SideW'(1);
        rb_d   = band_last ? '0 : rb_q + SideW'(1);
        st_d   = ST_CHK_WAIT;
      end
      ST_CHK_WAIT: begin
        // Hold until the column sweep of a finished band is through
        if (!tile_sts.busy) begin
          if (tile_sts.hit) begin
            res_done_d  = 1'b1;
            res_steps_d = k_q;
            st_d        = ST_RESP;
          end else if (rowc_q != side) begin
            st_d = ST_CHK_RD;
          end else if (k_q == maxit_q || (k_q != '0 && !moved_q)) begin
            // Out of steps, or the grid froze: report the full count
            res_steps_d = maxit_q;
            st_d        = ST_RESP;
          end else begin
            rowc_d  = '0;
            moved_d = 1'b0;
            st_d    = ST_RED_RD;
          end
        end
      end
      ST_RED_RD: begin
        st_d = ST_RED_DT;
      end
      ST_RED_DT: begin
        ram_we  = 1'b1;
        moved_d = moved_q | upd_changed;
        if (rowc_q == side - SideW'(1)) begin
          // Blue pass reads the last row first, then rows from the top
          bc_d = '0;
          st_d = ST_BLU_RD;
        end else begin
          rowc_d = rowc_q + SideW'(1);
          st_d   = ST_RED_RD;
        end
      end
      ST_BLU_RD: begin
        st_d = ST_BLU_DT;
      end
      ST_BLU_DT: begin
        bc_d = bc_q + SideW'(1);
        if (bc_q == '0) begin
          prev_d = ram_rdata;
          rowc_d = '0;
          st_d   = ST_BLU_RD;
        end else if (bc_q == SideW'(1)) begin
          cur_d  = ram_rdata;
          save_d = ram_rdata;
          rowc_d = SideW'(1);
          st_d   = ST_BLU_RD;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = IdxW'(bc_q - SideW'(2));
          moved_d   = moved_q | upd_changed;
          prev_d    = cur_q;
          cur_d     = ram_rdata;
          rowc_d    = rowc_q + SideW'(1);
          st_d      = (bc_q == side) ? ST_BLU_LAST : ST_BLU_RD;
        end
      end
      ST_BLU_LAST: begin
        // Close the wrap with the saved top row
        ram_we    = 1'b1;
        ram_waddr = IdxW'(side - SideW'(1));
        moved_d   = moved_q | upd_changed;
        k_d       = k_q + 16'd1;
        rowc_d    = '0;
        rb_d      = '0;
        st_d      = ST_CHK_RD;
      end
      ST_RESP: begin
        if (out_load) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      out_vld_q <= 1'b0;
      grid_q    <= RBTA_CFG_W'(64);
      tile_q    <= RBTA_CFG_W'(8);
      thr_q     <= RBTA_CFG_W'(RBTA_PCT);
      maxit_q   <= 16'd1000;
    end else begin
      st_q <= st_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GRID_SIZE: grid_q  <= cfg_data_i[RBTA_CFG_W-1:0];
          CFG_TILE_SIZE: tile_q  <= cfg_data_i[RBTA_CFG_W-1:0];
          CFG_THRESHOLD: thr_q   <= cfg_data_i[RBTA_CFG_W-1:0];
          CFG_MAX_ITER:  maxit_q <= cfg_data_i;
          default:       maxit_q <= maxit_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    row_q       <= row_d;
    col_q       <= col_d;
    colour_q    <= colour_d;
    rowc_q      <= rowc_d;
    rb_q        <= rb_d;
    bc_q        <= bc_d;
    k_q         <= k_d;
    moved_q     <= moved_d;
    tt_q        <= tt_d;
    bound_q     <= bound_d;
    prev_q      <= prev_d;
    cur_q       <= cur_d;
    save_q      <= save_d;
    res_val_q   <= res_val_d;
    res_done_q  <= res_done_d;
    res_steps_q <= res_steps_d;
    if (out_load) begin
      out_val_q   <= res_val_q;
      out_done_q  <= res_done_q;
      out_steps_q <= res_steps_q;
    end
  end

endmodule

// ===== src/rbta_ram.sv =====
module rbta_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/rbta_row_upd.sv =====
module rbta_row_upd
  import rbta_pkg::*;
#(
  parameter int unsigned GridMax = RBTA_GRID_MAX
) (
  input  logic                           is_red_i,
  input  logic [$clog2(GridMax+1)-1:0]   side_i,
  input  logic [GridMax-1:0][1:0]        prev_i,
  input  logic [GridMax-1:0][1:0]        cur_i,
  input  logic [GridMax-1:0][1:0]        next_i,
  output logic [GridMax-1:0][1:0]        row_o,
  output logic                           changed_o
);

  localparam int unsigned SideW = $clog2(GridMax + 1);
  localparam int unsigned IdxW  = $clog2(GridMax);

  logic [1:0] last_cell;
  logic [1:0] mover;
  logic [1:0] behind;
  logic [1:0] ahead;

  // Cell at the wrap column of the active grid
  assign last_cell = cur_i[IdxW'(side_i - SideW'(1))];
  assign mover     = is_red_i ? CELL_RED : CELL_BLUE;

  always_comb begin
    row_o     = cur_i;
    changed_o = 1'b0;
    behind    = CELL_EMPTY;
    ahead     = CELL_EMPTY;
    for (int c = 0; c < GridMax; c++) begin
      if (is_red_i) begin
        behind = (c == 0) ? last_cell : cur_i[(c + GridMax - 1) % GridMax];
        ahead  = (SideW'(c + 1) == side_i) ? cur_i[0] : cur_i[(c + 1) % GridMax];
      end else begin
        behind = prev_i[c];
        ahead  = next_i[c];
      end
      if (SideW'(c) < side_i) begin
        if (cur_i[c] == mover && ahead == CELL_EMPTY) begin
          row_o[c]  = CELL_EMPTY;
          changed_o = 1'b1;
        end else if (cur_i[c] == CELL_EMPTY && behind == mover) begin
          row_o[c]  = mover;
          changed_o = 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/rbta_tile_chk.sv =====
module rbta_tile_chk
  import rbta_pkg::*;
#(
  parameter int unsigned GridMax = RBTA_GRID_MAX
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rbta_tile_ctl_t               ctl_i,
  input  logic [GridMax-1:0][1:0]      row_i,
  input  logic [$clog2(GridMax+1)-1:0] side_i,
  input  logic [RBTA_CFG_W-1:0]        tile_i,
  input  logic [RBTA_BND_W-1:0]        bound_i,
  output rbta_tile_sts_t               sts_o
);

  localparam int unsigned SideW = $clog2(GridMax + 1);
  localparam int unsigned CntW  = $clog2(GridMax + 1);
  localparam int unsigned CmpW  = (SideW > RBTA_CFG_W ? SideW : RBTA_CFG_W) + 1;
  localparam int unsigned AccN  = $clog2(GridMax * GridMax * RBTA_PCT + 1);
  localparam int unsigned AccW  = AccN > RBTA_BND_W ? AccN : RBTA_BND_W;

  logic [CntW-1:0] red_q  [GridMax];
  logic [CntW-1:0] blue_q [GridMax];
  logic [SideW-1:0] sc_q;
  logic [SideW-1:0] cb_q;
  logic [AccW-1:0]  acc_r_q;
  logic [AccW-1:0]  acc_b_q;
  logic             busy_q;
  logic             hit_q;

  logic [AccW-1:0] sum_r;
  logic [AccW-1:0] sum_b;
  logic            tile_end;
  logic            over;

  // Column sums arrive at lane 0 as the counters shift down
  assign sum_r    = acc_r_q + AccW'(red_q[0]) * AccW'(RBTA_PCT);
  assign sum_b    = acc_b_q + AccW'(blue_q[0]) * AccW'(RBTA_PCT);
  assign tile_end = CmpW'(cb_q) == CmpW'(tile_i) - CmpW'(1);
  assign over     = (sum_r > AccW'(bound_i)) || (sum_b > AccW'(bound_i));

  assign sts_o.busy = busy_q;
  assign sts_o.hit  = hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      if (ctl_i.start) begin
        hit_q <= 1'b0;
      end else if (busy_q && tile_end && over) begin
        hit_q <= 1'b1;
      end
      if (ctl_i.row_vld && ctl_i.band_last) begin
        busy_q <= 1'b1;
      end else if (busy_q && sc_q == side_i - SideW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.row_vld) begin
      for (int c = 0; c < GridMax; c++) begin
        red_q[c]  <= (ctl_i.band_first ? '0 : red_q[c]) + CntW'(row_i[c] == CELL_RED);
        blue_q[c] <= (ctl_i.band_first ? '0 : blue_q[c]) + CntW'(row_i[c] == CELL_BLUE);
      end
      sc_q    <= '0;
      cb_q    <= '0;
      acc_r_q <= '0;
      acc_b_q <= '0;
    end else if (busy_q) begin
      for (int c = 0; c < GridMax - 1; c++) begin
        red_q[c]  <= red_q[c + 1];
        blue_q[c] <= blue_q[c + 1];
      end
      red_q[GridMax-1]  <= '0;
      blue_q[GridMax-1] <= '0;
      sc_q <= sc_q + SideW'(1);
      if (tile_end) begin
        cb_q    <= '0;
        acc_r_q <= '0;
        acc_b_q <= '0;
      end else begin
        cb_q    <= cb_q + SideW'(1);
        acc_r_q <= sum_r;
        acc_b_q <= sum_b;
      end
    end
  end

endmodule

// ===== tb/tb_red_blue_torus_automaton.sv =====
`timescale 1ns / 100ps

module tb_red_blue_torus_automaton;
  import rbta_pkg::*;

  localparam int unsigned GMAX       = RBTA_GRID_MAX;
  localparam int unsigned CYCLE_CAP  = 10000000;
  localparam int unsigned RAND_ITEMS = 900;

  // One request and one response as the predictor sees them
  typedef struct {
    logic [1:0] mode;
    logic [5:0] row;
    logic [5:0] col;
    logic [1:0] colour;
  } cell_req_t;

  typedef struct {
    logic [1:0]  value;
    logic        done;
    logic [15:0] steps;
  } cell_rsp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_data;

  rbta_req_if req_bus ();
  rbta_rsp_if rsp_bus ();

  red_blue_torus_automaton u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Predictor state: a shadow of the grid and of the four registers
  logic [1:0]  shadow_grid [GMAX][GMAX];
  bit          cell_known  [GMAX][GMAX];
  logic [6:0]  reg_side;
  logic [6:0]  reg_tile;
  logic [6:0]  reg_pct;
  logic [15:0] reg_iters;

  cell_rsp_t   pending_rsp [$];
  int unsigned err_count;
  int unsigned sent_count;
  int unsigned run_count;
  int unsigned done_count;
  int unsigned cycle_count;
  int unsigned hold_request;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, pending_rsp.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Out-of-range sizes clamp to the legal side
  function automatic int unsigned live_side();
    if (reg_side < 2) return 2;
    if (reg_side > GMAX) return GMAX;
    return reg_side;
  endfunction

  // True when some whole tile holds strictly more than the threshold share
  function automatic bit tile_over(int unsigned n);
    int unsigned t, tiles, bound, reds, blues;
    t = reg_tile;
    if (t == 0 || t > n) return 1'b0;
    tiles = n / t;
    bound = reg_pct * t * t;
    for (int unsigned a = 0; a < tiles; a++) begin
      for (int unsigned b = 0; b < tiles; b++) begin
        reds  = 0;
        blues = 0;
        for (int unsigned r = a * t; r < a * t + t; r++) begin
          for (int unsigned c = b * t; c < b * t + t; c++) begin
            if (shadow_grid[r][c] == CELL_RED) reds++;
            else if (shadow_grid[r][c] == CELL_BLUE) blues++;
          end
        end
        if (reds * 100 > bound || blues * 100 > bound) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Red half step: every red moves right into a cell empty at the start
  function automatic bit shift_reds(int unsigned n);
    logic [1:0] line [GMAX];
    int unsigned nx;
    bit moved;
    moved = 1'b0;
    for (int unsigned r = 0; r < n; r++) begin
      for (int unsigned c = 0; c < n; c++) line[c] = shadow_grid[r][c];
      for (int unsigned c = 0; c < n; c++) begin
        nx = (c + 1 == n) ? 0 : c + 1;
        if (line[c] == CELL_RED && line[nx] == CELL_EMPTY) begin
          shadow_grid[r][c]  = CELL_EMPTY;
          shadow_grid[r][nx] = CELL_RED;
          moved = 1'b1;
        end
      end
    end
    return moved;
  endfunction

  // Blue half step: every blue moves down the same way
  function automatic bit shift_blues(int unsigned n);
    logic [1:0] line [GMAX];
    int unsigned nx;
    bit moved;
    moved = 1'b0;
    for (int unsigned c = 0; c < n; c++) begin
      for (int unsigned r = 0; r < n; r++) line[r] = shadow_grid[r][c];
      for (int unsigned r = 0; r < n; r++) begin
        nx = (r + 1 == n) ? 0 : r + 1;
        if (line[r] == CELL_BLUE && line[nx] == CELL_EMPTY) begin
          shadow_grid[r][c]  = CELL_EMPTY;
          shadow_grid[nx][c] = CELL_BLUE;
          moved = 1'b1;
        end
      end
    end
    return moved;
  endfunction

  // Apply one request to the shadow and return the response it causes
  function automatic cell_rsp_t apply_request(cell_req_t q);
    cell_rsp_t   p;
    int unsigned n, k;
    bit          mr, mb;
    p = '{value: CELL_EMPTY, done: 1'b0, steps: '0};
    n = live_side();
    case (q.mode)
      MODE_WRITE: begin
        if (q.row < n && q.col < n)
          shadow_grid[q.row][q.col] = (q.colour == CELL_BAD) ? CELL_EMPTY : q.colour;
      end
      MODE_READ: begin
        if (q.row < n && q.col < n) p.value = shadow_grid[q.row][q.col];
      end
      MODE_RUN: begin
        if (tile_over(n)) begin
          p.done = 1'b1;
        end else begin
          k = 0;
          while (k < reg_iters) begin
            mr = shift_reds(n);
            mb = shift_blues(n);
            k++;
            if (tile_over(n)) begin
              p.done = 1'b1;
              break;
            end
            // Nothing moved: the grid is frozen for good
            if (!mr && !mb) begin
              k = reg_iters;
              break;
            end
          end
          p.steps = k[15:0];
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers and response checker
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    err_count++;
    $display("mismatch on %s at cycle %0d: got %0d, want %0d", field, cycle_count, got,
             want);
  endtask

  // Compare every accepted response with the oldest prediction
  always @(posedge clk_i) begin
    cell_rsp_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected response", 1, 0);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_bus.cell_value !== want.value)
          report_mismatch("cell_value", rsp_bus.cell_value, want.value);
        if (rsp_bus.done_flag !== want.done)
          report_mismatch("done_flag", rsp_bus.done_flag, want.done);
        if (rsp_bus.steps_done !== want.steps)
          report_mismatch("steps_done", rsp_bus.steps_done, want.steps);
        if (want.steps != 0 || want.done) begin
          run_count++;
          if (want.done) done_count++;
        end
      end
    end
  end

  // Response ready: random stalls, mostly short, plus any long hold asked for
  always @(posedge clk_i) begin
    int unsigned stall_left;
    int unsigned pick;
    if (hold_request != 0) begin
      stall_left   = hold_request;
      hold_request = 0;
    end
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      rsp_bus.ready <= 1'b0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        rsp_bus.ready <= 1'b1;
      end else begin
        rsp_bus.ready <= 1'b0;
        stall_left = (pick < 95) ? $urandom_range(0, 3) : $urandom_range(10, 60);
      end
    end
  end

  // Offer one request, predict its response on acceptance, then maybe idle
  task automatic send_request(logic [1:0] mode, logic [5:0] row, logic [5:0] col,
                              logic [1:0] colour, bit allow_gap = 1'b1);
    cell_req_t   q;
    int unsigned pick, gap;
    q = '{mode: mode, row: row, col: col, colour: colour};
    req_bus.valid  <= 1'b1;
    req_bus.mode   <= mode;
    req_bus.row    <= row;
    req_bus.col    <= col;
    req_bus.colour <= colour;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    if (mode == MODE_WRITE && row < live_side() && col < live_side())
      cell_known[row][col] = 1'b1;
    pending_rsp.push_back(apply_request(q));
    sent_count++;
    pick = $urandom_range(0, 99);
    gap  = !allow_gap ? 0 : (pick < 60) ? 0 : (pick < 92) ? $urandom_range(1, 3)
                                                          : $urandom_range(10, 40);
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold the sender until every predicted response has come back
  task automatic drain_responses();
    @(posedge clk_i);
    req_bus.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CFG_GRID_SIZE: reg_side  = data[6:0];
      CFG_TILE_SIZE: reg_tile  = data[6:0];
      CFG_THRESHOLD: reg_pct   = data[6:0];
      default:       reg_iters = data;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [6:0] side, logic [6:0] tile, logic [6:0] pct,
                            logic [15:0] iters);
    drain_responses();
    write_reg(CFG_GRID_SIZE, {9'd0, side});
    write_reg(CFG_TILE_SIZE, {9'd0, tile});
    write_reg(CFG_THRESHOLD, {9'd0, pct});
    write_reg(CFG_MAX_ITER, iters);
  endtask

  function automatic logic [1:0] random_colour(int unsigned empty_pct);
    if ($urandom_range(0, 99) < empty_pct) return CELL_EMPTY;
    return 2'($urandom_range(1, 3));
  endfunction

  // Write every cell of the active grid not yet written, so runs never see garbage
  task automatic fill_unknown(int unsigned empty_pct);
    int unsigned n;
    n = live_side();
    for (int unsigned r = 0; r < n; r++)
      for (int unsigned c = 0; c < n; c++)
        if (!cell_known[r][c])
          send_request(MODE_WRITE, 6'(r), 6'(c), random_colour(empty_pct));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Smallest grid: clamp of tiny sizes, odd colour code, unused mode, addresses
  // outside the grid, a finish at the start, a run with no tiles and a zero step budget
  task automatic test_small_grid_corners();
    set_config(7'd0, 7'd1, 7'd50, 16'd5);
    send_request(MODE_WRITE, 6'd0, 6'd0, CELL_RED);
    send_request(MODE_WRITE, 6'd0, 6'd1, CELL_BAD);
    send_request(MODE_WRITE, 6'd1, 6'd0, CELL_BLUE);
    send_request(MODE_WRITE, 6'd1, 6'd1, CELL_EMPTY);
    send_request(MODE_WRITE, 6'd2, 6'd0, CELL_RED);
    send_request(MODE_WRITE, 6'd63, 6'd63, CELL_BLUE);
    send_request(MODE_READ, 6'd0, 6'd1, CELL_EMPTY);
    send_request(MODE_READ, 6'd0, 6'd2, CELL_EMPTY);
    send_request(MODE_READ, 6'd63, 6'd0, CELL_EMPTY);
    send_request(2'd3, 6'd63, 6'd63, CELL_BAD);
    // One cell per tile and a half share: every occupied tile finishes at once
    send_request(MODE_RUN, 6'd0, 6'd0, CELL_EMPTY);
    // No tiles at all: the run goes the distance or freezes
    set_config(7'd1, 7'd0, 7'd0, 16'd5);
    send_request(MODE_RUN, 6'd0, 6'd0, CELL_EMPTY);
    send_request(MODE_READ, 6'd0, 6'd0, CELL_EMPTY);
    send_request(MODE_READ, 6'd0, 6'd1, CELL_EMPTY);
    send_request(MODE_READ, 6'd1, 6'd0, CELL_EMPTY);
    send_request(MODE_READ, 6'd1, 6'd1, CELL_EMPTY);
    // Tile larger than the grid, zero step budget
    set_config(7'd2, 7'd3, 7'd100, 16'd0);
    send_request(MODE_RUN, 6'd0, 6'd0, CELL_EMPTY);
  endtask

  // Frozen grid with the largest step budget: one step, then all of them reported
  task automatic test_frozen_grid();
    set_config(7'd4, 7'd2, 7'd100, 16'hFFFF);
    for (int unsigned r = 0; r < 4; r++)
      for (int unsigned c = 0; c < 4; c++)
        send_request(MODE_WRITE, 6'(r), 6'(c), CELL_EMPTY);
    send_request(MODE_RUN, 6'd0, 6'd0, CELL_EMPTY);
    // A full row of reds cannot move either
    for (int unsigned c = 0; c < 4; c++) send_request(MODE_WRITE, 6'd1, 6'(c), CELL_RED);
    send_request(MODE_RUN, 6'd0, 6'd0, CELL_EMPTY);
  endtask

  // Largest grid via an oversized register: far corners, and a run that sweeps
  // nothing because the tile is past the grid and the step budget is zero
  task automatic test_full_grid();
    set_config(7'd127, 7'd64, 7'd0, 16'd2);
    send_request(MODE_WRITE, 6'd63, 6'd63, CELL_BLUE);
    send_request(MODE_WRITE, 6'd0, 6'd63, CELL_RED);
    send_request(MODE_READ, 6'd63, 6'd63, CELL_EMPTY);
    send_request(MODE_READ, 6'd0, 6'd63, CELL_EMPTY);
    set_config(7'd64, 7'd127, 7'd127, 16'd0);
    send_request(MODE_RUN, 6'd0, 6'd0, CELL_EMPTY);
    send_request(MODE_READ, 6'd63, 6'd63, CELL_EMPTY);
  endtask

  // Hold responses off for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    set_config(7'd8, 7'd4, 7'd60, 16'd4);
    fill_unknown(50);
    hold_request = 400;
    for (int unsigned i = 0; i < 24; i++) begin
      if (i % 6 == 5) send_request(MODE_RUN, 6'd0, 6'd0, CELL_EMPTY, 1'b0);
      else send_request($urandom_range(0, 1) ? MODE_WRITE : MODE_READ,
                        6'($urandom_range(0, 7)), 6'($urandom_range(0, 7)),
                        random_colour(40), 1'b0);
    end
  endtask

  // Random phases: fresh settings, complete the grid, then mixed traffic
  task automatic test_random_traffic();
    int unsigned n, pick, start;
    logic [5:0]  r, c;
    logic [6:0]  tile;
    start = sent_count;
    while (sent_count - start < RAND_ITEMS) begin
      n    = $urandom_range(2, 16);
      tile = ($urandom_range(0, 3) != 0) ? 7'($urandom_range(1, n))
                                         : 7'($urandom_range(0, 70));
      set_config(($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 1)) : 7'(n), tile,
                 7'($urandom_range(0, 127)), 16'($urandom_range(0, 30)));
      n = live_side();
      fill_unknown($urandom_range(20, 80));
      for (int unsigned i = 0; i < 70; i++) begin
        pick = $urandom_range(0, 99);
        // Mostly in-range addresses; some land outside to probe the guard
        if ($urandom_range(0, 9) == 0) begin
          r = 6'($urandom_range(0, 63));
          c = 6'($urandom_range(0, 63));
        end else begin
          r = 6'($urandom_range(0, n - 1));
          c = 6'($urandom_range(0, n - 1));
        end
        if (pick < 45) send_request(MODE_WRITE, r, c, random_colour(40));
        else if (pick < 80) send_request(MODE_READ, r, c, 2'($urandom_range(0, 3)));
        else if (pick < 95) send_request(MODE_RUN, r, c, 2'($urandom_range(0, 3)));
        else send_request(2'd3, r, c, 2'($urandom_range(0, 3)));
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_GRID_SIZE;
    cfg_data       = '0;
    req_bus.valid  = 1'b0;
    req_bus.mode   = MODE_WRITE;
    req_bus.row    = '0;
    req_bus.col    = '0;
    req_bus.colour = CELL_EMPTY;
    reg_side       = 7'd64;
    reg_tile       = 7'd8;
    reg_pct        = 7'd100;
    reg_iters      = 16'd1000;
    hold_request   = 0;
    for (int r = 0; r < GMAX; r++)
      for (int c = 0; c < GMAX; c++) begin
        shadow_grid[r][c] = CELL_EMPTY;
        cell_known[r][c]  = 1'b0;
      end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_small_grid_corners();
    test_frozen_grid();
    test_output_backpressure();
    test_random_traffic();
    test_full_grid();

    drain_responses();
    repeat (64) @(posedge clk_i);
    $display("covered %0d requests: %0d runs (%0d finished), grid sides 2 to 64,",
             sent_count, run_count, done_count);
    $display("clamped sizes, missing tiles, frozen grids and a long response stall");
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/rbta_pkg.sv
src/rbta_if.sv
src/rbta_ram.sv
src/rbta_row_upd.sv
src/rbta_tile_chk.sv
src/red_blue_torus_automaton.sv
tb/tb_red_blue_torus_automaton.sv
